// ----- design/slbm_pkg.sv -----
// Shared constants, codes and types of the serial-loaded bank mapper.
// Used by the interfaces, the shifter, the bank map and the top level.
package slbm_pkg;

  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 8;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int BLK_W     = 7;
  localparam int BANK_W    = 8;
  localparam int CREG_W    = 5;
  localparam int REGION_W  = 2;
  localparam int COUNT_W   = 3;
  localparam int OUTER_W   = 7;
  localparam int CREG_N    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PRG_BLOCKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_IS_RAM = 2'd1;

  localparam logic [REGION_W-1:0] REG_CTRL = 2'd0;
  localparam logic [REGION_W-1:0] REG_CHR0 = 2'd1;
  localparam logic [REGION_W-1:0] REG_CHR1 = 2'd2;
  localparam logic [REGION_W-1:0] REG_PRG  = 2'd3;

  localparam logic [2:0]         COMMIT_NONE   = 3'd4;
  localparam logic [COUNT_W-1:0] SHIFT_LAST    = 3'd4;
  localparam logic [BLK_W-1:0]   BLOCKS_RESET  = 7'd16;
  localparam logic [BLK_W-1:0]   BLOCKS_512K   = 7'd32;
  localparam logic [BLK_W-1:0]   BLOCKS_1024K  = 7'd64;
  localparam logic [CREG_W-1:0]  CTRL_RESET    = 5'h0c;
  localparam logic [OUTER_W-1:0] OUTER_FIXED   = 7'h60;
  localparam logic [BANK_W-1:0]  FIXED_LARGE   = 8'(256 / 8 - 2);

  typedef struct packed {
    logic                valid;
    logic [REGION_W-1:0] region;
    logic [CREG_W-1:0]   value;
  } commit_t;

  typedef struct packed {
    logic [2:0]        committed_reg;
    logic [1:0]        mirroring;
    logic [BANK_W-1:0] prg_bank_8000;
    logic [BANK_W-1:0] prg_bank_a000;
    logic [BANK_W-1:0] prg_bank_c000;
    logic [BANK_W-1:0] prg_bank_e000;
    logic [BANK_W-1:0] chr_low_base;
    logic [BANK_W-1:0] chr_high_base;
  } result_t;

endpackage

// ----- design/slbm_if.sv -----
// Request and result channel interfaces of the bank mapper.
// Depends on slbm_pkg for field widths.
interface slbm_req_if;
  logic                          valid;
  logic                          ready;
  logic [slbm_pkg::ADDR_W-1:0]   cpu_addr;
  logic [slbm_pkg::DATA_W-1:0]   write_data;

  modport source (output valid, output cpu_addr, output write_data, input ready);
  modport sink   (input valid, input cpu_addr, input write_data, output ready);
endinterface

interface slbm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    committed_reg;
  logic [1:0]                    mirroring;
  logic [slbm_pkg::BANK_W-1:0]   prg_bank_8000;
  logic [slbm_pkg::BANK_W-1:0]   prg_bank_a000;
  logic [slbm_pkg::BANK_W-1:0]   prg_bank_c000;
  logic [slbm_pkg::BANK_W-1:0]   prg_bank_e000;
  logic [slbm_pkg::BANK_W-1:0]   chr_low_base;
  logic [slbm_pkg::BANK_W-1:0]   chr_high_base;

  modport source (output valid, output committed_reg, output mirroring,
                  output prg_bank_8000, output prg_bank_a000, output prg_bank_c000,
                  output prg_bank_e000, output chr_low_base, output chr_high_base,
                  input ready);
  modport sink   (input valid, input committed_reg, input mirroring,
                  input prg_bank_8000, input prg_bank_a000, input prg_bank_c000,
                  input prg_bank_e000, input chr_low_base, input chr_high_base,
                  output ready);
endinterface

// ----- design/slbm_shifter.sv -----
// Five-bit serial load shifter: collects data bit 0 per write, clears on
// bit 7 or on a region change, and emits a commit. Depends on slbm_pkg.
module slbm_shifter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic [slbm_pkg::REGION_W-1:0]   region,
  input  logic [slbm_pkg::DATA_W-1:0]     write_data,
  output slbm_pkg::commit_t               cmt
);

  logic [slbm_pkg::COUNT_W-1:0]  shift_count;
  logic [slbm_pkg::CREG_W-1:0]   shift_bits;
  logic [slbm_pkg::REGION_W-1:0] last_region;

  logic [slbm_pkg::COUNT_W-1:0]  count_cur;
  logic [slbm_pkg::CREG_W-1:0]   bits_cur;
  logic [slbm_pkg::CREG_W-1:0]   bits_next;
  logic                          last_bit;
  logic                          clear;

  always_comb begin
    count_cur = (region == last_region) ? shift_count : '0;
    bits_cur  = (region == last_region) ? shift_bits : '0;
    bits_next = bits_cur | (slbm_pkg::CREG_W'(write_data[0]) << count_cur);
    last_bit  = (count_cur == slbm_pkg::SHIFT_LAST);
    clear     = write_data[slbm_pkg::DATA_W-1];
    cmt.valid  = en && !clear && last_bit;
    cmt.region = region;
    cmt.value  = bits_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_count <= '0;
      shift_bits  <= '0;
      last_region <= '0;
    end else if (en) begin
      last_region <= region;
      if (clear || last_bit) begin
        shift_count <= '0;
        shift_bits  <= '0;
      end else begin
        shift_count <= count_cur + 3'd1;
        shift_bits  <= bits_next;
      end
    end
  end

endmodule

// ----- design/slbm_bank_map.sv -----
// Mapper registers and bank mapping: mirroring, program slots with the
// outer bank, character bases, and the size configuration. Depends on slbm_pkg.
module slbm_bank_map (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [slbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slbm_pkg::CFG_W-1:0]       cfg_data,
  input  slbm_pkg::commit_t                cmt,
  output slbm_pkg::result_t                res
);

  localparam int BW = slbm_pkg::BANK_W;

  function automatic logic [BW-1:0] fixed_slot(input logic [slbm_pkg::BLK_W-1:0] blocks,
                                               input logic k);
    logic [BW-1:0] s;
    if (blocks == slbm_pkg::BLOCKS_512K || blocks == slbm_pkg::BLOCKS_1024K) begin
      s = slbm_pkg::FIXED_LARGE + BW'(k);
    end else begin
      s = BW'({blocks, 1'b0}) - 8'd2 + BW'(k);
    end
    return s;
  endfunction

  logic [slbm_pkg::BLK_W-1:0]                     prg_16k_blocks;
  logic                                           chr_is_ram;
  logic [slbm_pkg::CREG_N-1:0][slbm_pkg::CREG_W-1:0] mapper_regs, mapper_regs_next;
  logic                                           outer_swap_pending, outer_swap_pending_next;
  logic [slbm_pkg::OUTER_W-1:0]                   outer_base, outer_base_next;
  logic [3:0][BW-1:0]                             prg_slots, prg_slots_next;
  logic [1:0]                                     mirror_mode, mirror_mode_next;
  logic [1:0][BW-1:0]                             chr_bases, chr_bases_next;

  logic                               is_1024k;
  logic                               is_512k;
  logic                               is_small;
  logic [slbm_pkg::CREG_W-1:0]        c0;
  logic [BW-1:0]                      v4;
  logic [BW-1:0]                      b;
  logic [BW-1:0]                      bq;
  logic [slbm_pkg::OUTER_W-1:0]       outer_r1;
  logic [slbm_pkg::OUTER_W-1:0]       outer_r12;

  always_comb begin
    is_1024k = (prg_16k_blocks == slbm_pkg::BLOCKS_1024K);
    is_512k  = (prg_16k_blocks == slbm_pkg::BLOCKS_512K);
    is_small = !is_1024k && !is_512k;

    mapper_regs_next        = mapper_regs;
    outer_swap_pending_next = outer_swap_pending;
    outer_base_next         = outer_base;
    prg_slots_next          = prg_slots;
    mirror_mode_next        = mirror_mode;
    chr_bases_next          = chr_bases;

    if (cmt.valid) begin
      mapper_regs_next[cmt.region] = cmt.value;
    end
    c0        = mapper_regs_next[slbm_pkg::REG_CTRL];
    v4        = BW'({cmt.value, 2'b00});
    b         = BW'({cmt.value[3:0], 1'b0});
    bq        = b & 8'h1c;
    outer_r1  = {1'b0, mapper_regs_next[slbm_pkg::REG_CHR0][4], 5'b0};
    outer_r12 = {mapper_regs_next[slbm_pkg::REG_CHR1][4],
                 mapper_regs_next[slbm_pkg::REG_CHR0][4], 5'b0};

    if (cmt.valid) begin
      case (cmt.region)
        slbm_pkg::REG_CTRL: begin
          mirror_mode_next = c0[1:0];
        end
        slbm_pkg::REG_CHR0: begin
          if (is_1024k) begin
            if (c0[4]) begin
              if (outer_swap_pending) begin
                outer_base_next         = c0[3] ? outer_r12 : outer_r1;
                outer_swap_pending_next = 1'b0;
              end else begin
                outer_swap_pending_next = 1'b1;
              end
            end else begin
              outer_base_next = mapper_regs_next[slbm_pkg::REG_CHR0][4] ?
                                slbm_pkg::OUTER_FIXED : '0;
            end
          end else if (is_512k && chr_is_ram) begin
            outer_base_next = outer_r1;
          end else if (!chr_is_ram) begin
            chr_bases_next[0] = v4;
            if (!c0[4]) begin
              chr_bases_next[1] = v4 + 8'd4;
            end
          end else if (c0[4]) begin
            chr_bases_next[0] = v4;
          end
        end
        slbm_pkg::REG_CHR1: begin
          if (is_1024k && c0[3]) begin
            if (outer_swap_pending) begin
              outer_base_next         = outer_r12;
              outer_swap_pending_next = 1'b0;
            end else begin
              outer_swap_pending_next = 1'b1;
            end
          end
          if (c0[4]) begin
            chr_bases_next[1] = v4;
          end
        end
        slbm_pkg::REG_PRG: begin
          if (c0[3]) begin
            if (c0[2]) begin
              prg_slots_next[0] = b;
              prg_slots_next[1] = b + 8'd1;
              prg_slots_next[2] = fixed_slot(prg_16k_blocks, 1'b0);
              prg_slots_next[3] = fixed_slot(prg_16k_blocks, 1'b1);
            end else if (is_small) begin
              prg_slots_next[0] = 8'd0;
              prg_slots_next[1] = 8'd1;
              prg_slots_next[2] = b;
              prg_slots_next[3] = b + 8'd1;
            end
          end else begin
            prg_slots_next[0] = bq;
            prg_slots_next[1] = bq + 8'd1;
            if (is_small) begin
              prg_slots_next[2] = bq + 8'd2;
              prg_slots_next[3] = bq + 8'd3;
            end
          end
        end
        default: begin
        end
      endcase
    end

    res.committed_reg = cmt.valid ? {1'b0, cmt.region} : slbm_pkg::COMMIT_NONE;
    res.mirroring     = mirror_mode_next;
    res.prg_bank_8000 = BW'({1'b0, outer_base_next}) + prg_slots_next[0];
    res.prg_bank_a000 = BW'({1'b0, outer_base_next}) + prg_slots_next[1];
    res.prg_bank_c000 = BW'({1'b0, outer_base_next}) + prg_slots_next[2];
    res.prg_bank_e000 = BW'({1'b0, outer_base_next}) + prg_slots_next[3];
    res.chr_low_base  = chr_bases_next[0];
    res.chr_high_base = chr_bases_next[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_16k_blocks     <= slbm_pkg::BLOCKS_RESET;
      chr_is_ram         <= 1'b0;
      mapper_regs        <= {5'd0, 5'd0, 5'd0, slbm_pkg::CTRL_RESET};
      outer_swap_pending <= 1'b0;
      outer_base         <= '0;
      prg_slots          <= {8'd31, 8'd30, 8'd1, 8'd0};
      mirror_mode        <= '0;
      chr_bases          <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        slbm_pkg::CFG_PRG_BLOCKS: begin
          prg_16k_blocks <= cfg_data;
          prg_slots      <= {fixed_slot(cfg_data, 1'b1), fixed_slot(cfg_data, 1'b0),
                             8'd1, 8'd0};
        end
        slbm_pkg::CFG_CHR_IS_RAM: begin
          chr_is_ram <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end else begin
      mapper_regs        <= mapper_regs_next;
      outer_swap_pending <= outer_swap_pending_next;
      outer_base         <= outer_base_next;
      prg_slots          <= prg_slots_next;
      mirror_mode        <= mirror_mode_next;
      chr_bases          <= chr_bases_next;
    end
  end

endmodule

// ----- design/serial_loaded_bank_mapper.sv -----
// Serial-loaded bank mapper: accepts one CPU write request per clock while
// the result channel is not stalled, and returns one mapping result per
// request. A request is registered in the request register, passes the
// shifter and bank logic and lands in the result register; a new request
// can be taken while the previous one moves into the result register.
// While a result waits, one more request is still taken. Write configuration
// only while no request is in flight. Depends on slbm_pkg, slbm_if,
// slbm_shifter and slbm_bank_map.
module serial_loaded_bank_mapper (
  input  logic                             clk,
  input  logic                             rst,
  slbm_req_if.sink                         req,
  slbm_rsp_if.source                       rsp,
  input  logic                             cfg_we,
  input  logic [slbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slbm_pkg::CFG_W-1:0]       cfg_data
);

  logic                           busy;
  logic [slbm_pkg::ADDR_W-1:0]    addr_q;
  logic [slbm_pkg::DATA_W-1:0]    data_q;
  logic                           rsp_valid;
  slbm_pkg::result_t              rsp_q;
  slbm_pkg::result_t              res;
  slbm_pkg::commit_t              cmt;
  logic                           advance;
  logic                           take;

  assign advance   = busy && (!rsp_valid || rsp.ready);
  assign req.ready = !busy || advance;
  assign take      = req.valid && req.ready;

  slbm_shifter u_shifter (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .region     (addr_q[14:13]),
    .write_data (data_q),
    .cmt        (cmt)
  );

  slbm_bank_map u_map (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmt       (cmt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (take) begin
        busy <= 1'b1;
      end else if (advance) begin
        busy <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      addr_q <= req.cpu_addr;
      data_q <= req.write_data;
    end
    if (advance) begin
      rsp_q <= res;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.committed_reg = rsp_q.committed_reg;
  assign rsp.mirroring     = rsp_q.mirroring;
  assign rsp.prg_bank_8000 = rsp_q.prg_bank_8000;
  assign rsp.prg_bank_a000 = rsp_q.prg_bank_a000;
  assign rsp.prg_bank_c000 = rsp_q.prg_bank_c000;
  assign rsp.prg_bank_e000 = rsp_q.prg_bank_e000;
  assign rsp.chr_low_base  = rsp_q.chr_low_base;
  assign rsp.chr_high_base = rsp_q.chr_high_base;

endmodule

// ----- design/slbm_checker.sv -----
// Port-level checks of the bank mapper, bound to the top level.
// Depends on serial_loaded_bank_mapper and slbm_pkg.
module slbm_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rsp_valid,
  input  logic                          rsp_ready,
  input  logic [2:0]                    committed_reg,
  input  logic [slbm_pkg::BANK_W-1:0]   prg_bank_8000,
  input  logic [slbm_pkg::BANK_W-1:0]   prg_bank_a000,
  input  logic [slbm_pkg::BANK_W-1:0]   prg_bank_c000,
  input  logic [slbm_pkg::BANK_W-1:0]   prg_bank_e000
);

  a_empty_after_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_low_pair: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> prg_bank_a000 == 8'(prg_bank_8000 + 8'd1))
    else $error("bank at a000 does not follow bank at 8000");

  a_high_pair: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> prg_bank_e000 == 8'(prg_bank_c000 + 8'd1))
    else $error("bank at e000 does not follow bank at c000");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(committed_reg)
      && $stable(prg_bank_8000) && $stable(prg_bank_c000))
    else $error("stalled result changed");

endmodule

bind serial_loaded_bank_mapper slbm_checker u_slbm_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .committed_reg (rsp.committed_reg),
  .prg_bank_8000 (rsp.prg_bank_8000),
  .prg_bank_a000 (rsp.prg_bank_a000),
  .prg_bank_c000 (rsp.prg_bank_c000),
  .prg_bank_e000 (rsp.prg_bank_e000)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench of serial_loaded_bank_mapper: sends CPU write requests with random idling on
// both channels, predicts the mapping after every write and checks each result field.
// Depends on slbm_pkg, the slbm_req_if / slbm_rsp_if interfaces and the design files.
module tb_top;

  localparam int QUIET_LIMIT = 4000;
  localparam int GAP_CAP     = 16;
  localparam int DRAIN_WAIT  = 4;
  localparam int PHASE_LEN   = 38;
  localparam logic [slbm_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [slbm_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef enum logic [1:0] {ROM_SMALL, ROM_512K, ROM_1024K} rom_kind_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [slbm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [slbm_pkg::CFG_W-1:0]     cfg_data;

  slbm_req_if req_ch();
  slbm_rsp_if rsp_ch();

  serial_loaded_bank_mapper DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [slbm_pkg::BLK_W-1:0]    cfg_blocks;
  logic                          cfg_chr_ram;
  logic [slbm_pkg::COUNT_W-1:0]  sh_count;
  logic [slbm_pkg::CREG_W-1:0]   sh_bits;
  logic [slbm_pkg::REGION_W-1:0] prev_region;
  logic [slbm_pkg::CREG_W-1:0]   mreg [slbm_pkg::CREG_N];
  logic                          outer_toggle_wait;
  logic [slbm_pkg::OUTER_W-1:0]  outer_bank;
  logic [slbm_pkg::BANK_W-1:0]   slot_bank [4];
  logic [1:0]                    mirror_sel;
  logic [slbm_pkg::BANK_W-1:0]   chr_base [2];

  slbm_pkg::result_t pending_mappings [$];
  int      mismatch_count = 0;
  int      quiet_cycles = 0;
  int      writes_sent = 0;
  int      tx_idle_pct;
  int      rx_idle_pct;

  function automatic rom_kind_t rom_kind();
    if (cfg_blocks == slbm_pkg::BLOCKS_1024K) return ROM_1024K;
    if (cfg_blocks == slbm_pkg::BLOCKS_512K) return ROM_512K;
    return ROM_SMALL;
  endfunction

  function automatic logic [slbm_pkg::BANK_W-1:0] last_bank(input int k);
    if (rom_kind() == ROM_SMALL)
      return slbm_pkg::BANK_W'(int'(cfg_blocks) * 2 - 2 + k);
    return slbm_pkg::FIXED_LARGE + slbm_pkg::BANK_W'(k);
  endfunction

  function automatic logic [slbm_pkg::OUTER_W-1:0] outer_from(input logic with_chr1);
    return {with_chr1 & mreg[slbm_pkg::REG_CHR1][4], mreg[slbm_pkg::REG_CHR0][4], 5'd0};
  endfunction

  task automatic reload_slots();
    slot_bank[0] = 8'd0;
    slot_bank[1] = 8'd1;
    slot_bank[2] = last_bank(0);
    slot_bank[3] = last_bank(1);
  endtask

  task automatic reset_mapping();
    cfg_blocks = slbm_pkg::BLOCKS_RESET;
    cfg_chr_ram = 1'b0;
    sh_count = '0;
    sh_bits = '0;
    prev_region = slbm_pkg::REG_CTRL;
    mreg[slbm_pkg::REG_CTRL] = slbm_pkg::CTRL_RESET;
    mreg[slbm_pkg::REG_CHR0] = '0;
    mreg[slbm_pkg::REG_CHR1] = '0;
    mreg[slbm_pkg::REG_PRG] = '0;
    outer_toggle_wait = 1'b0;
    outer_bank = '0;
    reload_slots();
    mirror_sel = 2'd0;
    chr_base[0] = '0;
    chr_base[1] = '0;
  endtask

  task automatic toggle_outer(input logic with_chr1);
    if (outer_toggle_wait) begin
      outer_bank = outer_from(with_chr1);
      outer_toggle_wait = 1'b0;
    end else begin
      outer_toggle_wait = 1'b1;
    end
  endtask

  task automatic apply_commit(input logic [slbm_pkg::REGION_W-1:0] r);
    logic [slbm_pkg::CREG_W-1:0] ctrl;
    logic [slbm_pkg::CREG_W-1:0] v;
    logic [slbm_pkg::BANK_W-1:0] b;
    ctrl = mreg[slbm_pkg::REG_CTRL];
    v = mreg[r];
    case (r)
      slbm_pkg::REG_CTRL: mirror_sel = ctrl[1:0];
      slbm_pkg::REG_CHR0: begin
        if (rom_kind() == ROM_1024K) begin
          if (ctrl[4]) toggle_outer(ctrl[3]);
          else outer_bank = v[4] ? slbm_pkg::OUTER_FIXED : '0;
        end else if (rom_kind() == ROM_512K && cfg_chr_ram) begin
          outer_bank = outer_from(1'b0);
        end else if (!cfg_chr_ram) begin
          chr_base[0] = slbm_pkg::BANK_W'({v, 2'b00});
          if (!ctrl[4]) chr_base[1] = slbm_pkg::BANK_W'({v, 2'b00}) + 8'd4;
        end else if (ctrl[4]) begin
          chr_base[0] = slbm_pkg::BANK_W'({v, 2'b00});
        end
      end
      slbm_pkg::REG_CHR1: begin
        if (rom_kind() == ROM_1024K && ctrl[3]) toggle_outer(1'b1);
        if (ctrl[4]) chr_base[1] = slbm_pkg::BANK_W'({v, 2'b00});
      end
      slbm_pkg::REG_PRG: begin
        b = slbm_pkg::BANK_W'({v[3:0], 1'b0});
        if (ctrl[3]) begin
          if (ctrl[2]) begin
            slot_bank[0] = b;
            slot_bank[1] = b + 8'd1;
            slot_bank[2] = last_bank(0);
            slot_bank[3] = last_bank(1);
          end else if (rom_kind() == ROM_SMALL) begin
            slot_bank[0] = 8'd0;
            slot_bank[1] = 8'd1;
            slot_bank[2] = b;
            slot_bank[3] = b + 8'd1;
          end
        end else begin
          b = b & 8'h1c;
          slot_bank[0] = b;
          slot_bank[1] = b + 8'd1;
          if (rom_kind() == ROM_SMALL) begin
            slot_bank[2] = b + 8'd2;
            slot_bank[3] = b + 8'd3;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic predict_mapping(input logic [slbm_pkg::ADDR_W-1:0] addr,
                                 input logic [slbm_pkg::DATA_W-1:0] data,
                                 output slbm_pkg::result_t m);
    logic [slbm_pkg::REGION_W-1:0] region;
    region = addr[14:13];
    m.committed_reg = slbm_pkg::COMMIT_NONE;
    if (region != prev_region) begin
      sh_count = '0;
      sh_bits = '0;
    end
    prev_region = region;
    if (data[7]) begin
      sh_count = '0;
      sh_bits = '0;
    end else begin
      sh_bits = sh_bits | (slbm_pkg::CREG_W'(data[0]) << sh_count);
      if (sh_count == slbm_pkg::SHIFT_LAST) begin
        mreg[region] = sh_bits;
        sh_count = '0;
        sh_bits = '0;
        m.committed_reg = {1'b0, region};
        apply_commit(region);
      end else begin
        sh_count = sh_count + 1'b1;
      end
    end
    m.mirroring = mirror_sel;
    m.prg_bank_8000 = slbm_pkg::BANK_W'(outer_bank) + slot_bank[0];
    m.prg_bank_a000 = slbm_pkg::BANK_W'(outer_bank) + slot_bank[1];
    m.prg_bank_c000 = slbm_pkg::BANK_W'(outer_bank) + slot_bank[2];
    m.prg_bank_e000 = slbm_pkg::BANK_W'(outer_bank) + slot_bank[3];
    m.chr_low_base = chr_base[0];
    m.chr_high_base = chr_base[1];
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_mapping(input slbm_pkg::result_t want);
    check_field("committed_reg", 8'(want.committed_reg), 8'(rsp_ch.committed_reg));
    check_field("mirroring", 8'(want.mirroring), 8'(rsp_ch.mirroring));
    check_field("prg_bank_8000", want.prg_bank_8000, rsp_ch.prg_bank_8000);
    check_field("prg_bank_a000", want.prg_bank_a000, rsp_ch.prg_bank_a000);
    check_field("prg_bank_c000", want.prg_bank_c000, rsp_ch.prg_bank_c000);
    check_field("prg_bank_e000", want.prg_bank_e000, rsp_ch.prg_bank_e000);
    check_field("chr_low_base", want.chr_low_base, rsp_ch.chr_low_base);
    check_field("chr_high_base", want.chr_high_base, rsp_ch.chr_high_base);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_mappings.size() == 0) begin
        $error("mapping result with no request pending");
        mismatch_count++;
      end else begin
        check_mapping(pending_mappings.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("[serial_loaded_bank_mapper] ERROR");
    $finish;
  end

  always @(negedge clk) begin
    rsp_ch.ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_write(input logic [slbm_pkg::ADDR_W-1:0] addr,
                            input logic [slbm_pkg::DATA_W-1:0] data);
    int                gap;
    slbm_pkg::result_t m;
    gap = 0;
    while (gap < GAP_CAP && $urandom_range(99) < tx_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cpu_addr <= addr;
    req_ch.write_data <= data;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_mapping(addr, data, m);
    pending_mappings.push_back(m);
    writes_sent++;
  endtask

  task automatic hold_requests();
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  task automatic wait_results();
    while (pending_mappings.size() != 0) @(posedge clk);
  endtask

  task automatic drain_block();
    hold_requests();
    wait_results();
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_config(input logic [slbm_pkg::CFG_IDX_W-1:0] idx,
                              input logic [slbm_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      slbm_pkg::CFG_PRG_BLOCKS: begin
        cfg_blocks = value;
        reload_slots();
      end
      slbm_pkg::CFG_CHR_IS_RAM: cfg_chr_ram = value[0];
      default: ;
    endcase
  endtask

  function automatic logic [slbm_pkg::ADDR_W-1:0] region_addr(
      input logic [slbm_pkg::REGION_W-1:0] region);
    return {1'b1, region, 13'($urandom_range(8191))};
  endfunction

  task automatic shift_in(input logic [slbm_pkg::ADDR_W-1:0] addr,
                          input logic [slbm_pkg::CREG_W-1:0] word,
                          input int len, input logic [5:0] fill);
    for (int i = 0; i < len; i++) send_write(addr, {1'b0, fill, word[i]});
  endtask

  task automatic random_writes(input int n);
    int                            stop_at;
    int                            pick;
    logic [slbm_pkg::REGION_W-1:0] region;
    logic [slbm_pkg::CREG_W-1:0]   word;
    stop_at = writes_sent + n;
    while (writes_sent < stop_at) begin
      pick = $urandom_range(99);
      region = slbm_pkg::REGION_W'($urandom_range(3));
      word = slbm_pkg::CREG_W'($urandom_range(31));
      if (pick < 4) begin
        hold_requests();
        wait_results();
      end else if (pick < 72) begin
        if ($urandom_range(1)) send_write(region_addr(region), {1'b1, 7'($urandom_range(127))});
        shift_in(region_addr(region), word, 5, 6'($urandom_range(63)));
      end else if (pick < 88) begin
        shift_in(region_addr(region), word, $urandom_range(1, 4), 6'($urandom_range(63)));
        if ($urandom_range(1))
          send_write(region_addr(region), {1'b1, 7'($urandom_range(127))});
        else
          send_write(region_addr(region + slbm_pkg::REGION_W'($urandom_range(1, 3))),
                     slbm_pkg::DATA_W'($urandom_range(255)));
      end else begin
        send_write(region_addr(region), slbm_pkg::DATA_W'($urandom_range(255)));
      end
    end
  endtask

  task automatic run_mapping_phase(input logic [slbm_pkg::BLK_W-1:0] blocks,
                                   input logic chr_ram);
    drain_block();
    write_config(slbm_pkg::CFG_PRG_BLOCKS, blocks);
    write_config(slbm_pkg::CFG_CHR_IS_RAM, {6'($urandom_range(63)), chr_ram});
    random_writes(PHASE_LEN);
  endtask

  task automatic test_clear_writes();
    send_write(16'h8000, 8'hff);
    send_write(16'hffff, 8'h80);
    send_write(16'hbfff, 8'hc1);
  endtask

  task automatic test_register_loads();
    shift_in(16'h9fff, 5'h1f, 5, 6'h3f);
    shift_in(16'he000, 5'h10, 5, 6'h00);
    shift_in(16'ha000, 5'h1f, 5, 6'h2a);
  endtask

  task automatic test_broken_loads();
    shift_in(16'he123, 5'h07, 3, 6'h15);
    shift_in(16'hc000, 5'h03, 2, 6'h00);
    send_write(16'hdfff, 8'h80);
    shift_in(16'hc001, 5'h01, 1, 6'h3f);
    send_write(16'h8001, 8'h01);
  endtask

  task automatic test_small_rom();
    run_mapping_phase(7'd1, 1'b0);
    run_mapping_phase(slbm_pkg::BLOCKS_RESET, 1'b1);
  endtask

  task automatic test_512k_rom();
    run_mapping_phase(slbm_pkg::BLOCKS_512K, 1'b1);
    run_mapping_phase(slbm_pkg::BLOCKS_512K, 1'b0);
  endtask

  task automatic test_1024k_rom();
    run_mapping_phase(slbm_pkg::BLOCKS_1024K, 1'b0);
    run_mapping_phase(slbm_pkg::BLOCKS_1024K, 1'b1);
    run_mapping_phase(slbm_pkg::BLOCKS_1024K, 1'($urandom_range(1)));
  endtask

  task automatic test_size_wrap();
    drain_block();
    write_config(CFG_SPARE_2, 7'($urandom_range(127)));
    write_config(CFG_SPARE_3, 7'($urandom_range(127)));
    run_mapping_phase(7'd0, 1'b0);
    run_mapping_phase(7'd127, 1'b1);
    run_mapping_phase(slbm_pkg::BLK_W'($urandom_range(127)), 1'($urandom_range(1)));
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = slbm_pkg::CFG_PRG_BLOCKS;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.cpu_addr = 16'h8000;
    req_ch.write_data = '0;
    rsp_ch.ready = 1'b0;
    tx_idle_pct = 24;
    rx_idle_pct = 59;
    reset_mapping();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_clear_writes();
    test_register_loads();
    test_broken_loads();
    test_small_rom();
    test_512k_rom();
    tx_idle_pct = 59;
    rx_idle_pct = 24;
    test_1024k_rom();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_size_wrap();

    drain_block();
    if (mismatch_count == 0) $display("[serial_loaded_bank_mapper] OK");
    else $display("[serial_loaded_bank_mapper] ERROR");
    $finish;
  end

endmodule
